// ===== src/kcq_pkg.sv =====
// kcq_pkg: shared types, codes and the squared-distance function of the
// k-means colour quantizer. No dependencies.
`timescale 1ns / 1ps

package kcq_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_CHANNELS = 4;
    localparam int CID_W        = 4;
    localparam int DIST_W       = 18;

    // Item actions
    typedef enum logic [1:0] {
        ACT_LOAD_PIXEL  = 2'd0,
        ACT_LOAD_CENTRE = 2'd1,
        ACT_START       = 2'd2,
        ACT_READ        = 2'd3
    } action_t;

    // Result kinds
    localparam logic RES_START = 1'b0;
    localparam logic RES_PIXEL = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_NUM_CLUSTERS   = 3'd0;
    localparam logic [2:0] REG_NUM_CHANNELS   = 3'd1;
    localparam logic [2:0] REG_PIXEL_COUNT    = 3'd2;
    localparam logic [2:0] REG_MAX_ITERATIONS = 3'd3;
    localparam logic [2:0] REG_STAB_THRESHOLD = 3'd4;

    typedef logic [MAX_CHANNELS-1:0][7:0] pix_t;

    // Clamped configuration as seen by the datapath
    typedef struct packed {
        logic [CID_W-1:0]  kmax;     // clusters in use minus one
        logic [1:0]        chm1;     // channels in use minus one
        logic [15:0]       max_iter;
        logic [DIST_W-1:0] thr;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_CHECK,
        ST_PASS_INIT,
        ST_FETCH,
        ST_DIST,
        ST_ACCUM,
        ST_DIV_LOAD,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr_i;
        logic clr_map_wr;
        logic start_init;
        logic pass_init;
        logic pix_rd;
        logic clr_p;
        logic dist_step;
        logic accum;
        logic div_load;
        logic div_step;
        logic upd_write;
        logic pass_end;
        logic out_read;
        logic out_start;
    } cmd_t;

    typedef struct packed {
        logic i_clear_last;
        logic i_last;
        logic n_zero;
        logic p_last;
        logic div_last;
        logic stop;
        logic out_busy;
    } sts_t;

    function automatic logic [DIST_W-1:0] sq_dist(pix_t a, pix_t b, logic [1:0] chm1);
        logic [DIST_W-1:0]  s;
        logic signed [8:0]  df;
        logic signed [17:0] prod;
        logic [15:0]        sq;
        s = '0;
        for (int d = 0; d < MAX_CHANNELS; d++) begin
            df   = $signed({1'b0, a[d]}) - $signed({1'b0, b[d]});
            prod = df * df;
            sq   = prod[15:0];
            if (2'(d) <= chm1) begin
                s = s + DIST_W'(sq);
            end
        end
        return s;
    endfunction

endpackage

// ===== src/kcq_ctrl.sv =====
// kcq_ctrl: sequencer of the k-means quantizer.
// Depends on kcq_pkg; drives the command struct of kcq_dpath.
`timescale 1ns / 1ps

module kcq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [1:0]      action,
    input  kcq_pkg::sts_t   sts,
    output logic            s_ready,
    output kcq_pkg::cmd_t   cmd
);

    kcq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kcq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            kcq_pkg::ST_IDLE: begin
                s_ready = !sts.out_busy;
                if (accept) begin
                    if (action == kcq_pkg::ACT_START) begin
                        cmd.clr_i  = 1'b1;
                        state_next = kcq_pkg::ST_CLEAR;
                    end else if (action == kcq_pkg::ACT_READ) begin
                        state_next = kcq_pkg::ST_READ;
                    end
                end
            end
            kcq_pkg::ST_READ: begin
                cmd.out_read = 1'b1;
                state_next   = kcq_pkg::ST_IDLE;
            end
            kcq_pkg::ST_CLEAR: begin
                cmd.clr_map_wr = 1'b1;
                if (sts.i_clear_last) begin
                    cmd.start_init = 1'b1;
                    state_next     = kcq_pkg::ST_CHECK;
                end
            end
            kcq_pkg::ST_CHECK: begin
                state_next = sts.stop ? kcq_pkg::ST_DONE : kcq_pkg::ST_PASS_INIT;
            end
            kcq_pkg::ST_PASS_INIT: begin
                cmd.pass_init = 1'b1;
                if (sts.n_zero) begin
                    cmd.clr_p  = 1'b1;
                    state_next = kcq_pkg::ST_DIV_LOAD;
                end else begin
                    state_next = kcq_pkg::ST_FETCH;
                end
            end
            kcq_pkg::ST_FETCH: begin
                cmd.pix_rd = 1'b1;
                cmd.clr_p  = 1'b1;
                state_next = kcq_pkg::ST_DIST;
            end
            kcq_pkg::ST_DIST: begin
                cmd.dist_step = 1'b1;
                if (sts.p_last) begin
                    state_next = kcq_pkg::ST_ACCUM;
                end
            end
            kcq_pkg::ST_ACCUM: begin
                cmd.accum = 1'b1;
                if (sts.i_last) begin
                    cmd.clr_p  = 1'b1;
                    state_next = kcq_pkg::ST_DIV_LOAD;
                end else begin
                    state_next = kcq_pkg::ST_FETCH;
                end
            end
            kcq_pkg::ST_DIV_LOAD: begin
                cmd.div_load = 1'b1;
                state_next   = kcq_pkg::ST_DIV;
            end
            kcq_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = kcq_pkg::ST_UPDATE;
                end
            end
            kcq_pkg::ST_UPDATE: begin
                cmd.upd_write = 1'b1;
                if (sts.p_last) begin
                    cmd.pass_end = 1'b1;
                    state_next   = kcq_pkg::ST_CHECK;
                end else begin
                    state_next = kcq_pkg::ST_DIV_LOAD;
                end
            end
            kcq_pkg::ST_DONE: begin
                cmd.out_start = 1'b1;
                state_next    = kcq_pkg::ST_IDLE;
            end
            default: begin
                state_next = kcq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/kcq_dpath.sv =====
// kcq_dpath: stores, distance unit, accumulators, dividers and result register.
// Depends on kcq_pkg; steered by kcq_ctrl.
`timescale 1ns / 1ps

module kcq_dpath #(
    parameter int MAX_PIXELS = 65536
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  kcq_pkg::cfg_t                          cfg,
    input  logic [$clog2(MAX_PIXELS+1)-1:0]        pix_count,
    input  logic                                   accept,
    input  logic [1:0]                             action,
    input  logic [15:0]                            item_index,
    input  kcq_pkg::pix_t                          item_val,
    input  kcq_pkg::cmd_t                          cmd,
    output kcq_pkg::sts_t                          sts,
    input  logic                                   m_ready,
    output logic                                   m_valid,
    output logic                                   m_result_kind,
    output logic [kcq_pkg::CID_W-1:0]              m_cluster_id,
    output kcq_pkg::pix_t                          m_chans,
    output logic [15:0]                            m_passes_run,
    output logic                                   m_converged
);

    localparam int NW  = $clog2(MAX_PIXELS + 1);
    localparam int PAW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SW  = NW + 8;
    localparam int CW  = 21;
    localparam int K   = kcq_pkg::MAX_CLUSTERS;
    localparam int CH  = kcq_pkg::MAX_CHANNELS;

    // Memories
    kcq_pkg::pix_t                  pix_mem [MAX_PIXELS];
    logic [kcq_pkg::CID_W-1:0]      map_mem [MAX_PIXELS];
    kcq_pkg::pix_t                  pix_q_reg;
    logic [kcq_pkg::CID_W-1:0]      map_q_reg;

    // Centre and accumulator registers
    kcq_pkg::pix_t                  centre_reg [K];
    logic [CH-1:0][SW-1:0]          sums_reg   [K];
    logic [NW-1:0]                  counts_reg [K];

    logic [NW-1:0]                  i_reg;
    logic [kcq_pkg::CID_W-1:0]      p_reg;
    logic [kcq_pkg::CID_W-1:0]      best_reg;
    logic [kcq_pkg::DIST_W-1:0]     best_d_reg;
    logic                           map_written_reg;
    logic                           rd_inr_reg;
    logic [15:0]                    pass_reg;
    logic                           stable_reg;
    logic                           stable_acc_reg;

    logic [CH-1:0][SW-1:0]          rem_reg;
    kcq_pkg::pix_t                  q_reg;
    logic [NW-1:0]                  den_reg;
    logic [2:0]                     bit_reg;

    logic [CW-1:0]                  idx_w;
    logic                           idx_inr;
    logic [PAW-1:0]                 idx_addr;
    logic [PAW-1:0]                 i_addr;
    logic [NW-1:0]                  i_inc;
    logic [kcq_pkg::CID_W-1:0]      cid;
    logic [kcq_pkg::CID_W-1:0]      cen_addr;
    logic [kcq_pkg::CID_W-1:0]      sum_addr;
    kcq_pkg::pix_t                  cen_rd;
    kcq_pkg::pix_t                  dist_a;
    logic [kcq_pkg::DIST_W-1:0]     dist_val;
    logic                           cnt_nz;
    logic                           move_big;
    logic [SW-1:0]                  div_sh;
    logic                           m_valid_reg;

    assign idx_w    = {5'b0, item_index};
    assign idx_inr  = idx_w < CW'(MAX_PIXELS);
    assign idx_addr = idx_w[PAW-1:0];
    assign i_addr   = i_reg[PAW-1:0];
    assign i_inc    = i_reg + 1'b1;

    assign cid      = (map_written_reg && rd_inr_reg) ? map_q_reg : '0;
    assign cen_addr = cmd.out_read ? cid : p_reg;
    assign sum_addr = cmd.accum ? best_reg : p_reg;
    assign cen_rd   = centre_reg[cen_addr];
    assign dist_a   = cmd.upd_write ? q_reg : pix_q_reg;
    assign dist_val = kcq_pkg::sq_dist(dist_a, cen_rd, cfg.chm1);
    assign cnt_nz   = counts_reg[p_reg] != '0;
    assign move_big = cnt_nz && (dist_val > cfg.thr);
    assign div_sh   = {8'b0, den_reg} << bit_reg;

    // Pixel store
    always_ff @(posedge aclk) begin
        if (accept && action == kcq_pkg::ACT_LOAD_PIXEL && idx_inr) begin
            pix_mem[idx_addr] <= item_val;
        end
        if (cmd.pix_rd) begin
            pix_q_reg <= pix_mem[i_addr];
        end
    end

    // Cluster map
    always_ff @(posedge aclk) begin
        if (cmd.clr_map_wr || cmd.accum) begin
            map_mem[i_addr] <= cmd.clr_map_wr ? '0 : best_reg;
        end
        if (accept && action == kcq_pkg::ACT_READ) begin
            map_q_reg <= map_mem[idx_addr];
        end
    end

    // Centres
    always_ff @(posedge aclk) begin
        if (accept && action == kcq_pkg::ACT_LOAD_CENTRE && item_index[15:4] == '0) begin
            centre_reg[item_index[3:0]] <= item_val;
        end else if (cmd.upd_write && cnt_nz) begin
            for (int d = 0; d < CH; d++) begin
                if (2'(d) <= cfg.chm1) begin
                    centre_reg[p_reg][d] <= q_reg[d];
                end
            end
        end
    end

    // Per-cluster sums and member counts
    always_ff @(posedge aclk) begin
        if (cmd.pass_init) begin
            for (int k = 0; k < K; k++) begin
                sums_reg[k]   <= '0;
                counts_reg[k] <= '0;
            end
        end else if (cmd.accum) begin
            for (int d = 0; d < CH; d++) begin
                sums_reg[sum_addr][d] <= sums_reg[sum_addr][d] + SW'(pix_q_reg[d]);
            end
            counts_reg[sum_addr] <= counts_reg[sum_addr] + 1'b1;
        end
    end

    // Restoring dividers, one quotient bit per cycle and lane
    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg <= sums_reg[sum_addr];
            den_reg <= counts_reg[sum_addr];
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            for (int d = 0; d < CH; d++) begin
                if (rem_reg[d] >= div_sh) begin
                    rem_reg[d]       <= rem_reg[d] - div_sh;
                    q_reg[d][bit_reg] <= 1'b1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg           <= '0;
            p_reg           <= '0;
            bit_reg         <= '0;
            map_written_reg <= 1'b0;
            pass_reg        <= '0;
            stable_reg      <= 1'b0;
            stable_acc_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.clr_i || cmd.pass_init) begin
                i_reg <= '0;
            end else if (cmd.clr_map_wr || cmd.accum) begin
                i_reg <= i_inc;
            end

            if (cmd.clr_p) begin
                p_reg <= '0;
            end else if (cmd.dist_step || cmd.upd_write) begin
                p_reg <= p_reg + 1'b1;
            end

            if (cmd.div_load) begin
                bit_reg <= 3'd7;
            end else if (cmd.div_step) begin
                bit_reg <= bit_reg - 1'b1;
            end

            if (cmd.start_init) begin
                map_written_reg <= 1'b1;
                pass_reg        <= '0;
                stable_reg      <= 1'b0;
            end
            if (cmd.pass_init) begin
                stable_acc_reg <= 1'b1;
            end else if (cmd.upd_write && move_big) begin
                stable_acc_reg <= 1'b0;
            end
            if (cmd.pass_end) begin
                pass_reg   <= pass_reg + 1'b1;
                stable_reg <= stable_acc_reg & ~move_big;
            end

            if (cmd.out_read || cmd.out_start) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Nearest-centre search and read address latch
    always_ff @(posedge aclk) begin
        if (cmd.dist_step && (p_reg == '0 || dist_val < best_d_reg)) begin
            best_reg   <= p_reg;
            best_d_reg <= dist_val;
        end
        if (accept && action == kcq_pkg::ACT_READ) begin
            rd_inr_reg <= idx_inr;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_read) begin
            m_result_kind <= kcq_pkg::RES_PIXEL;
            m_cluster_id  <= cid;
            for (int d = 0; d < CH; d++) begin
                m_chans[d] <= (2'(d) <= cfg.chm1) ? cen_rd[d] : 8'd0;
            end
            m_passes_run  <= pass_reg;
            m_converged   <= stable_reg;
        end else if (cmd.out_start) begin
            m_result_kind <= kcq_pkg::RES_START;
            m_cluster_id  <= '0;
            m_chans       <= '0;
            m_passes_run  <= pass_reg;
            m_converged   <= stable_reg;
        end
    end

    assign m_valid = m_valid_reg;

    assign sts.i_clear_last = i_reg == NW'(MAX_PIXELS - 1);
    assign sts.i_last       = i_inc == pix_count;
    assign sts.n_zero       = pix_count == '0;
    assign sts.p_last       = p_reg == cfg.kmax;
    assign sts.div_last     = bit_reg == 3'd0;
    assign sts.stop         = stable_reg || (pass_reg >= cfg.max_iter);
    assign sts.out_busy     = m_valid_reg;

endmodule

// ===== src/kmeans_color_quantizer.sv =====
// kmeans_color_quantizer: top level with configuration registers.
// Depends on kcq_pkg, kcq_ctrl and kcq_dpath.
`timescale 1ns / 1ps

// K-means colour quantizer. Items on the s_ channel load a pixel, load a
// centre, read a pixel's cluster and centre colour (the read passes through
// state ST_READ before the result register is loaded) or start clustering.
// A new item is taken only when the state machine is idle and the result
// register is empty. A start first clears the whole cluster map, one entry
// a cycle, then runs passes. A pass assigns each pixel with the single
// distance unit that compares one centre per cycle, then updates the means
// with the four bit-serial dividers that yield one quotient bit per cycle.
// pixel_count is capped at MAX_PIXELS. Until the first start every pixel
// reads back as cluster 0. Configuration writes take effect at once and are
// meant to happen while the block is idle.

module kmeans_color_quantizer #(
    parameter int MAX_PIXELS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [17:0] cfg_wdata,
    // item input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [15:0] s_item_index,
    input  logic [7:0]  s_chan0,
    input  logic [7:0]  s_chan1,
    input  logic [7:0]  s_chan2,
    input  logic [7:0]  s_chan3,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [3:0]  m_cluster_id,
    output logic [7:0]  m_out_chan0,
    output logic [7:0]  m_out_chan1,
    output logic [7:0]  m_out_chan2,
    output logic [7:0]  m_out_chan3,
    output logic [15:0] m_passes_run,
    output logic        m_converged
);

    localparam int NW = $clog2(MAX_PIXELS + 1);
    localparam int CW = 21;

    logic [4:0]  num_clusters_reg;
    logic [2:0]  num_channels_reg;
    logic [16:0] pixel_count_reg;
    logic [15:0] max_iterations_reg;
    logic [17:0] stab_threshold_reg;

    kcq_pkg::cfg_t  cfg;
    kcq_pkg::cmd_t  cmd;
    kcq_pkg::sts_t  sts;
    kcq_pkg::pix_t  item_val;
    kcq_pkg::pix_t  m_chans;
    logic [CW-1:0]  n_wide;
    logic [NW-1:0]  pix_count;
    logic           accept;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_clusters_reg   <= 5'd4;
            num_channels_reg   <= 3'd3;
            pixel_count_reg    <= '0;
            max_iterations_reg <= 16'd100;
            stab_threshold_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                kcq_pkg::REG_NUM_CLUSTERS:   num_clusters_reg   <= cfg_wdata[4:0];
                kcq_pkg::REG_NUM_CHANNELS:   num_channels_reg   <= cfg_wdata[2:0];
                kcq_pkg::REG_PIXEL_COUNT:    pixel_count_reg    <= cfg_wdata[16:0];
                kcq_pkg::REG_MAX_ITERATIONS: max_iterations_reg <= cfg_wdata[15:0];
                kcq_pkg::REG_STAB_THRESHOLD: stab_threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp registers to the supported ranges
    always_comb begin
        if (num_clusters_reg == '0) begin
            cfg.kmax = '0;
        end else if (num_clusters_reg > 5'(kcq_pkg::MAX_CLUSTERS)) begin
            cfg.kmax = 4'(kcq_pkg::MAX_CLUSTERS - 1);
        end else begin
            cfg.kmax = 4'(num_clusters_reg - 1'b1);
        end
        if (num_channels_reg == '0) begin
            cfg.chm1 = '0;
        end else if (num_channels_reg > 3'(kcq_pkg::MAX_CHANNELS)) begin
            cfg.chm1 = 2'(kcq_pkg::MAX_CHANNELS - 1);
        end else begin
            cfg.chm1 = 2'(num_channels_reg - 1'b1);
        end
        cfg.max_iter = max_iterations_reg;
        cfg.thr      = stab_threshold_reg;
        n_wide       = {4'b0, pixel_count_reg};
        if (n_wide > CW'(MAX_PIXELS)) begin
            n_wide = CW'(MAX_PIXELS);
        end
        pix_count = n_wide[NW-1:0];
    end

    assign accept   = s_valid & s_ready;
    assign item_val = {s_chan3, s_chan2, s_chan1, s_chan0};

    kcq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .action  (s_action),
        .sts     (sts),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    kcq_dpath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .pix_count     (pix_count),
        .accept        (accept),
        .action        (s_action),
        .item_index    (s_item_index),
        .item_val      (item_val),
        .cmd           (cmd),
        .sts           (sts),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_result_kind (m_result_kind),
        .m_cluster_id  (m_cluster_id),
        .m_chans       (m_chans),
        .m_passes_run  (m_passes_run),
        .m_converged   (m_converged)
    );

    assign m_out_chan0 = m_chans[0];
    assign m_out_chan1 = m_chans[1];
    assign m_out_chan2 = m_chans[2];
    assign m_out_chan3 = m_chans[3];

endmodule

// ===== src/kcq_checker.sv =====
// kcq_checker: port-level checks of the k-means quantizer, bound to the top.
// Depends on kmeans_color_quantizer.
`timescale 1ns / 1ps

module kcq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_result_kind,
    input logic [3:0]  m_cluster_id,
    input logic [7:0]  m_out_chan0,
    input logic [7:0]  m_out_chan1,
    input logic [7:0]  m_out_chan2,
    input logic [7:0]  m_out_chan3,
    input logic [15:0] m_passes_run,
    input logic        m_converged
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cluster_id) && $stable(m_passes_run)
            && $stable(m_result_kind) && $stable(m_converged))
        else $error("result changed while stalled");

    a_start_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == 1'b0 |-> m_cluster_id == 4'd0 && m_out_chan0 == 8'd0
            && m_out_chan1 == 8'd0 && m_out_chan2 == 8'd0 && m_out_chan3 == 8'd0)
        else $error("start result carries pixel data");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("item taken while result pending");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");

endmodule

bind kmeans_color_quantizer kcq_checker u_kcq_checker (.*);
